// ===== hw/rtl/gbss_pkg.sv =====
// Package for the Gini best-split search core: command and status types and constants.
// No dependencies.
package gbss_pkg;

  localparam int unsigned Q16_ONE = 65536;
  localparam int unsigned IMP_W = 17;
  localparam int unsigned CNT_OUT_W = 11;

  // Controller to datapath commands
  typedef struct packed {
    logic store;       // write the accepted sample
    logic mark_drop;   // flag a dropped sample
    logic tot_clr;     // start totals pass
    logic tot_acc;     // accumulate one label into totals
    logic thr_load;    // load threshold from read data
    logic cmp_acc;     // compare one stored value against threshold
    logic div_start;   // start impurity division
    logic keep;        // update best if strictly lower
    logic clear_set;   // clear set state after result
    logic addr_zero;   // reset scan address
    logic addr_inc;    // advance scan address
    logic outer_inc;   // advance threshold index
  } gbss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic scan_last;   // scan address is the last stored entry
    logic outer_last;  // threshold index is the last stored entry
    logic div_done;
  } gbss_sts_t;

endpackage

// ===== hw/rtl/gbss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gbss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/gbss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the impurity ratio.
// Depends on nothing.
module gbss_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [CntW-1:0] StepsLast = CntW'(NumW - 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  assign shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};

  // Shift-subtract iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepsLast) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;
endmodule

// ===== hw/rtl/gbss_datapath.sv =====
// Datapath: sample stores, counters, split scoring and best tracking.
// Depends on gbss_pkg, gbss_ram and gbss_div.
module gbss_datapath
  import gbss_pkg::*;
#(
  parameter int unsigned MaxSamples = 1024,
  parameter int unsigned ValueWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbss_cmd_t             cmd_i,
  output gbss_sts_t             sts_o,
  input  logic [31:0]           feature_value_i,
  input  logic                  class_label_i,
  output logic [31:0]           best_threshold_o,
  output logic [IMP_W-1:0]      best_impurity_o,
  output logic [CNT_OUT_W-1:0]  sample_count_o,
  output logic                  overflow_flag_o
);
  localparam int unsigned AW  = $clog2(MaxSamples);
  localparam int unsigned CW  = $clog2(MaxSamples + 1);
  localparam int unsigned DenW = 3 * CW;
  localparam int unsigned NumW = 3 * CW + 2 + 16;
  localparam logic [CW-1:0] Cap = CW'(MaxSamples);

  logic [CW-1:0] cnt_q, t1_q, a_q, a1_q;
  logic [AW-1:0] scan_q, outer_q, waddr;
  logic          drop_q;
  logic [IMP_W-1:0] best_imp_q;
  logic [31:0]   best_thr_q, thr_raw_q;
  logic [31:0]   rd_val;
  logic [0:0]    rd_lab;
  logic          rd_valid_q;   // read data of scan_q is valid this cycle
  logic          acc_q;        // compare pending on registered read data

  assign waddr = cnt_q[AW-1:0];

  gbss_ram #(.Width(32), .Depth(MaxSamples)) u_val (
    .clk_i, .we_i(cmd_i.store), .waddr_i(waddr), .wdata_i(feature_value_i),
    .raddr_i(cmd_i.thr_load ? outer_q : scan_q), .rdata_o(rd_val)
  );
  gbss_ram #(.Width(1), .Depth(MaxSamples)) u_lab (
    .clk_i, .we_i(cmd_i.store), .waddr_i(waddr), .wdata_i(class_label_i),
    .raddr_i(cmd_i.thr_load ? outer_q : scan_q), .rdata_o(rd_lab)
  );

  // Signed order of the stored values, from ValueWidth bits
  function automatic logic signed [ValueWidth-1:0] key(input logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return signed'(w[ValueWidth-1:0]);
  endfunction

  // Split scoring inputs
  logic [CW-1:0] a0, b0, b1, nr, n;
  logic [2*CW-1:0] p_l, p_r, nlnr;
  logic [DenW-1:0] t_l, t_r, den_q;
  logic [NumW-1:0] num_q, quo;
  logic            div_done;
  logic            stage_q;

  assign n  = cnt_q;
  assign a0 = a_q - a1_q;
  assign b1 = t1_q - a1_q;
  assign nr = n - a_q;
  assign b0 = nr - b1;

  // Cross terms of the two-sided numerator
  assign t_l = DenW'(p_l) * DenW'(nr);
  assign t_r = DenW'(p_r) * DenW'(a_q);

  gbss_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(stage_q), .num_i(num_q), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );

  // Two register stages of products ahead of the divider
  always_ff @(posedge clk_i) begin
    p_l  <= a0 * a1_q;
    p_r  <= b0 * b1;
    nlnr <= a_q * nr;
    if (cmd_i.div_start) begin
      // nl or nr zero makes the cross terms vanish, matching the one-sided forms
      if (nr == '0) begin
        num_q <= NumW'(p_l) << 17;
        den_q <= DenW'(a_q) * DenW'(n);
      end else if (a_q == '0) begin
        num_q <= NumW'(p_r) << 17;
        den_q <= DenW'(nr) * DenW'(n);
      end else begin
        num_q <= NumW'(t_l + t_r) << 17;
        den_q <= DenW'(nlnr) * DenW'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stage_q <= 1'b0;
    else         stage_q <= cmd_i.div_start;
  end

  // Counters, scan, best tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; drop_q <= 1'b0; t1_q <= '0; a_q <= '0; a1_q <= '0;
      scan_q <= '0; outer_q <= '0; best_imp_q <= IMP_W'(Q16_ONE);
      best_thr_q <= '0; rd_valid_q <= 1'b0; acc_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.tot_acc;
      acc_q      <= cmd_i.cmp_acc;
      if (cmd_i.store) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.mark_drop) drop_q <= 1'b1;
      if (cmd_i.addr_zero) scan_q <= '0;
      else if (cmd_i.addr_inc) scan_q <= scan_q + 1'b1;
      if (cmd_i.tot_clr) begin
        t1_q <= '0; outer_q <= '0;
      end
      if (rd_valid_q && rd_lab[0]) t1_q <= t1_q + 1'b1;
      if (cmd_i.thr_load) begin
        a_q <= '0; a1_q <= '0;
      end
      if (acc_q && (key(rd_val) <= key(thr_raw_q))) begin
        a_q  <= a_q + 1'b1;
        a1_q <= a1_q + CW'(rd_lab[0]);
      end
      if (cmd_i.outer_inc) outer_q <= outer_q + 1'b1;
      if (cmd_i.keep && (quo[IMP_W-1:0] < best_imp_q)) begin
        best_imp_q <= quo[IMP_W-1:0];
        best_thr_q <= thr_raw_q;
      end
      if (cmd_i.clear_set) begin
        cnt_q <= '0; drop_q <= 1'b0; best_imp_q <= IMP_W'(Q16_ONE);
        best_thr_q <= '0;
      end
    end
  end

  // Threshold latched from the registered read data once thr_pend_q, the registered thr_load, marks it valid
  logic thr_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_pend_q <= 1'b0;
    else         thr_pend_q <= cmd_i.thr_load;
  end
  always_ff @(posedge clk_i) begin
    if (thr_pend_q) thr_raw_q <= rd_val;
  end

  assign sts_o.full       = (cnt_q == Cap);
  assign sts_o.scan_last  = (CW'(scan_q) == CW'(cnt_q - 1'b1));
  assign sts_o.outer_last = (CW'(outer_q) == CW'(cnt_q - 1'b1));
  assign sts_o.div_done   = div_done;

  assign best_threshold_o = best_thr_q;
  assign best_impurity_o  = best_imp_q;
  assign sample_count_o   = CNT_OUT_W'(cnt_q);
  assign overflow_flag_o  = drop_q;
endmodule

// ===== hw/rtl/gbss_ctrl.sv =====
// Controller: load handshake, totals pass, per-threshold scan, result handshake.
// Depends on gbss_pkg.
module gbss_ctrl
  import gbss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_sample_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gbss_sts_t sts_i,
  output gbss_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    StLoad, StTot, StTotWait, StThr, StThrWait, StScan, StDrain, StProd, StDiv0,
    StDiv, StNext, StOut
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StOut);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          cmd_o.store     = !sts_i.full;
          cmd_o.mark_drop = sts_i.full;
          if (last_sample_i) begin
            state_d         = StTot;
            cmd_o.addr_zero = 1'b1;
            cmd_o.tot_clr   = 1'b1;
          end
        end
      end
      StTot: begin
        cmd_o.tot_acc  = 1'b1;
        cmd_o.addr_inc = 1'b1;
        if (sts_i.scan_last) state_d = StTotWait;
      end
      StTotWait: state_d = StThr;
      StThr: begin
        cmd_o.thr_load  = 1'b1;
        cmd_o.addr_zero = 1'b1;
        state_d         = StThrWait;
      end
      StThrWait: state_d = StScan;
      StScan: begin
        cmd_o.cmp_acc  = 1'b1;
        cmd_o.addr_inc = 1'b1;
        if (sts_i.scan_last) state_d = StDrain;
      end
      StDrain: state_d = StProd;
      // final counts settle into the product registers
      StProd: state_d = StDiv0;
      StDiv0: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.keep = 1'b1;
          state_d    = StNext;
        end
      end
      StNext: begin
        if (sts_i.outer_last) state_d = StOut;
        else begin
          cmd_o.outer_inc = 1'b1;
          state_d         = StThr;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.clear_set = 1'b1;
          state_d         = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StLoad;
    else         state_q <= state_d;
  end
endmodule

// ===== hw/rtl/gini_best_split_search_core.sv =====
// Gini best-split search core: top level joining controller and datapath.
// Depends on gbss_pkg, gbss_ctrl and gbss_datapath.
//
// Usage: samples enter on the input channel (feature_value_i, class_label_i,
// last_sample_i) with in_valid_i/in_ready_o, one beat per cycle while loading.
// Each beat is written to the sample RAM; beats past MaxSamples are dropped
// and set overflow_flag_o. The beat with last_sample_i set starts the search
// and in_ready_o stays low until the result beat is taken.
// Search: one totals pass over the stored labels, then for each of the N stored
// values a scan of all stored entries plus a bit-serial divide; the divider and
// the single-read sample RAM set the search time.
// The result beat (best_threshold_o, best_impurity_o, sample_count_o,
// overflow_flag_o) is held on out_valid_o until out_ready_i; a stalled
// receiver simply holds the core in that state. Taking the result clears the
// set state and reopens loading. Reset returns to loading with an empty set.
module gini_best_split_search_core
  import gbss_pkg::*;
#(
  parameter int unsigned MaxSamples = 1024,
  parameter int unsigned ValueWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          feature_value_i,
  input  logic                 class_label_i,
  input  logic                 last_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          best_threshold_o,
  output logic [IMP_W-1:0]     best_impurity_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  output logic                 overflow_flag_o
);
  gbss_cmd_t cmd;
  gbss_sts_t sts;

  gbss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .last_sample_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  gbss_datapath #(.MaxSamples(MaxSamples), .ValueWidth(ValueWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .feature_value_i, .class_label_i,
    .best_threshold_o, .best_impurity_o, .sample_count_o, .overflow_flag_o
  );
endmodule
